>>> rtl/pushbutton_soft_power_controller_core_assert.svh
// Assertion macros used by the power controller top level.
`ifndef PUSHBUTTON_SOFT_POWER_CONTROLLER_CORE_ASSERT_SVH
`define PUSHBUTTON_SOFT_POWER_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PBSPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pbspc assertion failed");
`define PBSPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pbspc assertion failed");
`else
`define PBSPC_ASSERT_SAME(lbl, ante, cons)
`define PBSPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/pbspc_pkg.sv
// Types, constants and helper functions of the pushbutton power controller.
package pbspc_pkg;

    localparam int CNT_W = 16;
    localparam int CFG_W = 16;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_ON     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_PULSE = 3'd4;

    localparam logic [CFG_W-1:0] MIN_ON_RESET     = 16'd5000;
    localparam logic [CFG_W-1:0] FORCE_OFF_RESET  = 16'd5000;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd10;
    localparam logic [CFG_W-1:0] FLASH_RESET      = 16'd250;
    localparam logic [CFG_W-1:0] KILL_PULSE_RESET = 16'd10;

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_LOCKED = 3'd1,
        MODE_READY  = 3'd2,
        MODE_KILL   = 3'd3,
        MODE_SHUT   = 3'd4,
        MODE_WAIT   = 3'd5
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_on_ms;
        logic [CFG_W-1:0] force_off_ms;
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] flash_ms;
        logic [CFG_W-1:0] kill_pulse_ms;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        logic  kill_drive;
        logic  led_on;
        logic  power_enable;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic cnt_gt(input logic [CNT_W-1:0] a, input logic [CFG_W-1:0] b);
        return CMP_W'(a) > CMP_W'(b);
    endfunction

    function automatic logic cnt_ge(input logic [CNT_W-1:0] a, input logic [CFG_W-1:0] b);
        return CMP_W'(a) >= CMP_W'(b);
    endfunction

endpackage

>>> rtl/pbspc_cfg_regs.sv
// Configuration register file of the pushbutton power controller.
module pbspc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pbspc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pbspc_pkg::CFG_W-1:0]   cfg_wdata,
    output pbspc_pkg::cfg_t               cfg
);

    pbspc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_on_ms     <= pbspc_pkg::MIN_ON_RESET;
            cfg_reg.force_off_ms  <= pbspc_pkg::FORCE_OFF_RESET;
            cfg_reg.debounce_ms   <= pbspc_pkg::DEBOUNCE_RESET;
            cfg_reg.flash_ms      <= pbspc_pkg::FLASH_RESET;
            cfg_reg.kill_pulse_ms <= pbspc_pkg::KILL_PULSE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pbspc_pkg::REG_MIN_ON:     cfg_reg.min_on_ms     <= cfg_wdata;
                pbspc_pkg::REG_FORCE_OFF:  cfg_reg.force_off_ms  <= cfg_wdata;
                pbspc_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ms   <= cfg_wdata;
                pbspc_pkg::REG_FLASH:      cfg_reg.flash_ms      <= cfg_wdata;
                pbspc_pkg::REG_KILL_PULSE: cfg_reg.kill_pulse_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/pbspc_step.sv
// Power mode state and the per-tick next-state logic.
module pbspc_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 button_level,
    input  logic                 confirm_level,
    input  pbspc_pkg::cfg_t      cfg,
    output pbspc_pkg::result_t   result
);

    localparam int W = pbspc_pkg::CNT_W;

    pbspc_pkg::mode_t mode_reg, mode_next;
    logic             request_reg, request_next;
    logic             button_prev_reg;
    logic             led_reg, led_next;
    logic [W-1:0]     since_reg, since_next;
    logic [W-1:0]     phase_reg, phase_next;
    logic [W-1:0]     hold_reg, hold_next;
    logic [W-1:0]     flash_reg, flash_next;

    always_comb begin
        logic [W-1:0]                  elapsed;
        logic [pbspc_pkg::CFG_W-1:0]   pulse_len;
        logic                          falling;
        logic                          press_ok;
        logic                          req;
        logic                          skip;
        logic                          off_due;

        mode_next  = mode_reg;
        led_next   = led_reg;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        flash_next = flash_reg;
        off_due    = 1'b0;
        skip       = 1'b0;

        falling  = button_prev_reg && !button_level;
        elapsed  = pbspc_pkg::sat_inc(since_reg);
        press_ok = falling && (mode_reg == pbspc_pkg::MODE_OFF ||
                   mode_reg == pbspc_pkg::MODE_LOCKED || mode_reg == pbspc_pkg::MODE_READY) &&
                   pbspc_pkg::cnt_gt(elapsed, cfg.debounce_ms);
        req        = request_reg || press_ok;
        since_next = press_ok ? '0 : elapsed;

        if (mode_reg == pbspc_pkg::MODE_LOCKED) begin
            phase_next = pbspc_pkg::sat_inc(phase_reg);
            if (pbspc_pkg::cnt_ge(phase_reg, cfg.min_on_ms)) begin
                mode_next = pbspc_pkg::MODE_READY;
            end
        end

        if (req) begin
            if (mode_next == pbspc_pkg::MODE_OFF) begin
                mode_next  = pbspc_pkg::MODE_LOCKED;
                phase_next = '0;
                led_next   = 1'b1;
            end else if (mode_next == pbspc_pkg::MODE_READY) begin
                mode_next  = pbspc_pkg::MODE_KILL;
                phase_next = '0;
                skip       = 1'b1;
            end
        end
        request_next = 1'b0;

        pulse_len = (cfg.kill_pulse_ms == '0) ? pbspc_pkg::CFG_W'(1) : cfg.kill_pulse_ms;

        if (!skip) begin
            unique case (mode_next)
                pbspc_pkg::MODE_KILL: begin
                    phase_next = pbspc_pkg::sat_inc(phase_reg);
                    if (pbspc_pkg::cnt_ge(phase_next, pulse_len)) begin
                        mode_next  = pbspc_pkg::MODE_SHUT;
                        flash_next = '0;
                        hold_next  = '0;
                    end
                end
                pbspc_pkg::MODE_SHUT: begin
                    flash_next = pbspc_pkg::sat_inc(flash_reg);
                    if (pbspc_pkg::cnt_gt(flash_next, cfg.flash_ms)) begin
                        led_next   = !led_next;
                        flash_next = '0;
                    end
                    if (!confirm_level) begin
                        off_due = 1'b1;
                    end
                    if (button_level) begin
                        hold_next = '0;
                    end else begin
                        hold_next = pbspc_pkg::sat_inc(hold_reg);
                        if (pbspc_pkg::cnt_gt(hold_next, cfg.force_off_ms)) begin
                            off_due = 1'b1;
                        end
                    end
                    if (off_due) begin
                        hold_next = '0;
                        if (button_level) begin
                            mode_next = pbspc_pkg::MODE_OFF;
                            led_next  = 1'b0;
                        end else begin
                            mode_next = pbspc_pkg::MODE_WAIT;
                        end
                    end
                end
                pbspc_pkg::MODE_WAIT: begin
                    if (button_level) begin
                        mode_next = pbspc_pkg::MODE_OFF;
                        led_next  = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= pbspc_pkg::MODE_OFF;
            request_reg     <= 1'b1;
            button_prev_reg <= 1'b1;
            led_reg         <= 1'b0;
            since_reg       <= '0;
            phase_reg       <= '0;
            hold_reg        <= '0;
            flash_reg       <= '0;
        end else if (step_en) begin
            mode_reg        <= mode_next;
            request_reg     <= request_next;
            button_prev_reg <= button_level;
            led_reg         <= led_next;
            since_reg       <= since_next;
            phase_reg       <= phase_next;
            hold_reg        <= hold_next;
            flash_reg       <= flash_next;
        end
    end

    assign result.mode         = mode_next;
    assign result.kill_drive   = (mode_next == pbspc_pkg::MODE_KILL);
    assign result.led_on       = led_next;
    assign result.power_enable = (mode_next != pbspc_pkg::MODE_OFF);

endmodule

>>> rtl/pushbutton_soft_power_controller_core.sv
// Top level of the pushbutton soft power controller.
// Each input item is one millisecond tick carrying the button level (bit 0)
// and the host kill-confirm level (bit 1). Each tick yields exactly one
// result item with power enable, LED, kill drive and the power mode.
// An accepted item sits in an input register until the result register is free;
// the next-state logic then updates the mode and counters and loads the result register.
// An item thus passes the input register and then the result register before m_tvalid.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; s_tready then drops.
// After reset the mode is off with a power-on request pending, so the first
// tick turns power on. Registers take their reset values and may be written
// through cfg_we, cfg_addr and cfg_wdata while no item is in flight.
`include "pushbutton_soft_power_controller_core_assert.svh"
module pushbutton_soft_power_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // button_level, confirm_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // power_enable, led_on, kill_drive, mode
    input  logic                            cfg_we,
    input  logic [pbspc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pbspc_pkg::CFG_W-1:0]     cfg_wdata
);

    pbspc_pkg::cfg_t    cfg;
    pbspc_pkg::result_t result;

    logic       in_valid_reg;
    logic       in_button_reg;
    logic       in_confirm_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_free;
    logic       step_en;

    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    pbspc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pbspc_step u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .button_level  (in_button_reg),
        .confirm_level (in_confirm_reg),
        .cfg           (cfg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_button_reg  <= s_tdata[0];
            in_confirm_reg <= s_tdata[1];
        end
        if (step_en) begin
            out_data_reg <= {2'b00, result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PBSPC_ASSERT_NEXT(a_step_loads_result, step_en, m_tvalid)
    `PBSPC_ASSERT_NEXT(a_blocked_input_holds, in_valid_reg && !out_free, in_valid_reg && m_tvalid)
    `PBSPC_ASSERT_SAME(a_power_follows_mode, m_tvalid, m_tdata[0] == (m_tdata[5:3] != pbspc_pkg::MODE_OFF))
    `PBSPC_ASSERT_SAME(a_kill_only_in_pulse, m_tvalid && m_tdata[2], m_tdata[5:3] == pbspc_pkg::MODE_KILL)

endmodule
